// ----- hw/rtl/ring_modulator_with_highpass_macros.svh -----
// Assertion macros for the ring modulator with high-pass filter.
// Each macro expects clk and rst to be visible where it is used.
`ifndef RING_MODULATOR_WITH_HIGHPASS_MACROS_SVH
`define RING_MODULATOR_WITH_HIGHPASS_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define RMH_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define RMH_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RMH_ASSERT_IMP(label, ante, cons)
`define RMH_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- hw/rtl/rmh_pkg.sv -----
// Shared types, constants and the sine table builder for the ring modulator.
// Depends on nothing; every module of the block imports it.
package rmh_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int PHASE_BITS      = 24;
  localparam int QTAB_LEN        = (1 << SINE_TABLE_BITS) + 1;
  localparam int SINE_ADDR_W     = SINE_TABLE_BITS + 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_WAVEFORM   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HP_COEFF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_GAIN   = 3'd3;

  // Carrier shapes.
  localparam logic [1:0] WAVE_SINE   = 2'd0;
  localparam logic [1:0] WAVE_SAW    = 2'd1;
  localparam logic [1:0] WAVE_SQUARE = 2'd2;

  localparam logic [16:0] UNITY_Q16 = 17'd65536;

  // Taylor series divisors (2k)(2k+1) for k = 1..8.
  localparam logic [63:0] TAYLOR_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                             64'd110, 64'd156, 64'd210, 64'd272};
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic signed [23:0] sample_in;
    logic               block_end;
  } rmh_in_t;

  typedef struct packed {
    logic signed [23:0] mod_out;
    logic               block_end_res;
  } rmh_out_t;

  typedef struct packed {
    logic [1:0]  waveform;
    logic [23:0] phase_step;
    logic [15:0] hp_coeff;
    logic [16:0] out_gain;
  } rmh_cfg_t;

  // One classified sample handed from the front end to the back end.
  typedef struct packed {
    logic signed [23:0] sample;
    logic               block_end;
    logic [16:0]        carrier;
  } rmh_job_t;

  typedef logic [16:0] sine_rom_t [QTAB_LEN];

  // sin(x) for x in [0, pi/2] given in Q30, result in Q1.16.
  function automatic logic [16:0] rmh_sine_q16(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    int          k;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[k-1];
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    r = (sum + 64'd8192) >> 14;
    return r[16:0];
  endfunction

  // Quarter-wave table, evaluated at elaboration.
  function automatic sine_rom_t rmh_build_sine_rom();
    sine_rom_t rom;
    int        i;
    for (i = 0; i < QTAB_LEN; i++) begin
      rom[i] = rmh_sine_q16((HALF_PI_Q30 * 64'(i)) >> SINE_TABLE_BITS);
    end
    return rom;
  endfunction

endpackage

// ----- hw/rtl/rmh_front.sv -----
// Front end: accepts samples, advances the carrier phase and forms the carrier.
// Depends on rmh_pkg; feeds rmh_queue.
module rmh_front
  import rmh_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  rmh_cfg_t cfg,
  input  logic     in_valid,
  output logic     in_stall,
  input  rmh_in_t  in_data,
  output logic     push,
  output rmh_job_t push_data,
  input  logic     full
);

  localparam sine_rom_t SINE_ROM = rmh_build_sine_rom();

  logic                   held_valid;
  logic signed [23:0]     held_sample;
  logic                   held_end;
  logic [PHASE_BITS-1:0]  phase;
  logic [PHASE_BITS-1:0]  phase_next;
  logic [PHASE_BITS-1:0]  step;
  logic [16:0]            rom_q;
  logic [SINE_ADDR_W-1:0] rom_addr;
  logic [SINE_TABLE_BITS-1:0] quarter_idx;
  logic [17:0]            sine_sum;
  logic [16:0]            carrier;
  logic                   accept;

  // The holding stage frees up as soon as its beat moves into the queue.
  assign in_stall = held_valid && full;
  assign accept   = in_valid && !in_stall;
  assign push     = held_valid && !full;

  // Phase step, masked to the phase width; a zero step counts as one.
  always_comb begin
    step = PHASE_BITS'(cfg.phase_step);
    if (step == '0) begin
      step = PHASE_BITS'(1);
    end
    phase_next = phase + step;
  end

  // Quarter-wave address: mirrored in the second and fourth quadrants.
  always_comb begin
    quarter_idx = phase_next[PHASE_BITS-3 -: SINE_TABLE_BITS];
    if (phase_next[PHASE_BITS-2]) begin
      rom_addr = SINE_ADDR_W'(1 << SINE_TABLE_BITS) - {1'b0, quarter_idx};
    end else begin
      rom_addr = {1'b0, quarter_idx};
    end
  end

  // Phase and holding stage; the phase register always matches the held beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      phase      <= '0;
    end else begin
      if (accept) begin
        held_valid <= 1'b1;
        phase      <= phase_next;
      end else if (push) begin
        held_valid <= 1'b0;
      end
    end
  end

  // Registered table read and sample payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      rom_q       <= SINE_ROM[rom_addr];
      held_sample <= in_data.sample_in;
      held_end    <= in_data.block_end;
    end
  end

  // Unipolar carrier in Q1.16; the sine form is (1 - sin) / 2 with a sign per half.
  always_comb begin
    if (phase[PHASE_BITS-1]) begin
      sine_sum = {1'b0, UNITY_Q16} + {1'b0, rom_q};
    end else begin
      sine_sum = {1'b0, UNITY_Q16} - {1'b0, rom_q};
    end
    unique case (cfg.waveform)
      WAVE_SINE:   carrier = sine_sum[17:1];
      WAVE_SAW:    carrier = {1'b0, phase[PHASE_BITS-1 -: 16]};
      WAVE_SQUARE: carrier = phase[PHASE_BITS-1] ? UNITY_Q16 : 17'd0;
      default:     carrier = 17'd0;
    endcase
  end

  assign push_data.sample    = held_sample;
  assign push_data.block_end = held_end;
  assign push_data.carrier   = carrier;

endmodule

// ----- hw/rtl/rmh_queue.sv -----
// Short queue of classified samples between the front end and the back end.
// Depends on rmh_pkg and the assertion macro header.
`include "ring_modulator_with_highpass_macros.svh"
module rmh_queue
  import rmh_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  rmh_job_t push_data,
  output logic     full,
  input  logic     pop,
  output rmh_job_t head,
  output logic     empty
);

  rmh_job_t               mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  assign full  = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  `RMH_ASSERT_IMP(a_no_push_full, full, !push)
  `RMH_ASSERT_IMP(a_no_pop_empty, empty, !pop)
  `RMH_ASSERT_NXT(a_pop_drains, pop && !push, count == $past(count) - QUEUE_CNT_W'(1))

endmodule

// ----- hw/rtl/rmh_back.sv -----
// Back end: high-pass filter, carrier and gain products, rounding and saturation.
// Depends on rmh_pkg and the assertion macro header; drains rmh_queue.
`include "ring_modulator_with_highpass_macros.svh"
module rmh_back
  import rmh_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  rmh_cfg_t cfg,
  input  logic     empty,
  input  rmh_job_t head,
  output logic     pop,
  output logic     out_valid,
  input  logic     out_stall,
  output rmh_out_t out_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FILT = 3'd1;
  localparam logic [2:0] S_LP   = 3'd2;
  localparam logic [2:0] S_MOD  = 3'd3;
  localparam logic [2:0] S_GLO  = 3'd4;
  localparam logic [2:0] S_GHI  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]         state;
  logic [2:0]         state_next;
  rmh_job_t           job;
  logic signed [23:0] hist;
  logic signed [24:0] hp;
  logic signed [20:0] hi_q;
  logic [37:0]        lo_q;
  logic signed [43:0] mul_q;
  logic signed [25:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [43:0] prod;
  logic signed [24:0] diff;
  logic signed [41:0] lp_sum;
  logic signed [41:0] lp_shift;
  logic signed [25:0] lp_wide;
  logic signed [23:0] lp;
  logic signed [24:0] hp_calc;
  logic signed [59:0] v_sum;
  logic signed [59:0] v_round;
  logic signed [27:0] r;
  logic signed [23:0] r_sat;
  logic               out_free;

  assign out_free = !out_valid || !out_stall;
  assign pop      = !empty && ((state == S_IDLE) || ((state == S_DONE) && out_free));

  // Operand selection for the one shared multiplier.
  always_comb begin
    diff  = {hist[23], hist} - {job.sample[23], job.sample};
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_FILT: begin
        mul_a = 26'(diff);
        mul_b = {2'b00, cfg.hp_coeff};
      end
      S_MOD: begin
        mul_a = 26'(hp);
        mul_b = {1'b0, job.carrier};
      end
      S_GLO: begin
        mul_a = {5'b0, mul_q[20:0]};
        mul_b = {1'b0, cfg.out_gain};
      end
      S_GHI: begin
        mul_a = 26'(hi_q);
        mul_b = {1'b0, cfg.out_gain};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;
  end

  // Low-pass value rounded from the filter product; it lies between x and history.
  always_comb begin
    lp_sum   = mul_q[41:0] + 42'sd32768;
    lp_shift = lp_sum >>> 16;
    lp_wide  = {{2{job.sample[23]}}, job.sample} + lp_shift[25:0];
    lp       = lp_wide[23:0];
    hp_calc  = {job.sample[23], job.sample} - {lp[23], lp};
  end

  // Recombine the gain partial products, round and saturate.
  always_comb begin
    v_sum   = (60'(mul_q) <<< 21) + 60'(lo_q);
    v_round = v_sum + 60'sd2147483648;
    r       = v_round[59:32];
    if (r > 28'sd8388607) begin
      r_sat = 24'sd8388607;
    end else if (r < -28'sd8388608) begin
      r_sat = -24'sd8388608;
    end else begin
      r_sat = r[23:0];
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  state_next = pop ? S_FILT : S_IDLE;
      S_FILT:  state_next = S_LP;
      S_LP:    state_next = S_MOD;
      S_MOD:   state_next = S_GLO;
      S_GLO:   state_next = S_GHI;
      S_GHI:   state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = pop ? S_FILT : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control state and filter history.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      hist      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_LP) begin
        hist <= lp;
      end
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      job <= head;
    end
    if ((state == S_FILT) || (state == S_MOD) || (state == S_GLO) || (state == S_GHI)) begin
      mul_q <= prod;
    end
    if (state == S_LP) begin
      hp <= hp_calc;
    end
    if (state == S_GLO) begin
      hi_q <= mul_q[41:21];
    end
    if (state == S_GHI) begin
      lo_q <= mul_q[37:0];
    end
    if ((state == S_DONE) && out_free) begin
      out_data.mod_out       <= r_sat;
      out_data.block_end_res <= job.block_end;
    end
  end

  `RMH_ASSERT_NXT(a_ghi_to_done, state == S_GHI, state == S_DONE)
  `RMH_ASSERT_NXT(a_done_delivers, (state == S_DONE) && out_free,
                  out_valid && (out_data.block_end_res == $past(job.block_end)))

endmodule

// ----- hw/rtl/ring_modulator_with_highpass.sv -----
// Ring modulator with one-pole high-pass filter: one sample in, one sample out.
// The back end sequencer runs filter, carrier and two gain partial products through one
// multiplier, and takes a new sample only once the previous one goes to the output.
// Synchronous active-high reset clears phase, filter history, the control state and
// the configuration registers (phase step resets to one); the sine table is constant
// and needs no fill.
module ring_modulator_with_highpass
  import rmh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rmh_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rmh_out_t              out_data
);

  rmh_cfg_t cfg;
  logic     push;
  rmh_job_t push_data;
  logic     full;
  logic     pop;
  rmh_job_t head;
  logic     empty;

  assign cfg_ready = 1'b1;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.waveform   <= WAVE_SINE;
      cfg.phase_step <= 24'd1;
      cfg.hp_coeff   <= '0;
      cfg.out_gain   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WAVEFORM:   cfg.waveform   <= cfg_data[1:0];
        CFG_PHASE_STEP: cfg.phase_step <= cfg_data;
        CFG_HP_COEFF:   cfg.hp_coeff   <= cfg_data[15:0];
        CFG_OUT_GAIN:   cfg.out_gain   <= cfg_data[16:0];
        default: begin
        end
      endcase
    end
  end

  rmh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  rmh_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  rmh_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for ring_modulator_with_highpass: directed table, then random phases.
// Depends on rmh_pkg and the block's RTL; carries its own carrier table and sample predictor.
module tb_top;
  import rmh_pkg::*;

  localparam int N_PHASES    = 12;
  localparam int PHASE_LEN   = 120;
  localparam int CFG_PAUSE   = 20;
  localparam int TAIL_CYCLES = 40;
  localparam int HOLD_AFTER  = 300;
  localparam int HOLD_CYCLES = 300;
  localparam int DIR_ROWS    = 38;

  localparam logic signed [23:0] S_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] S_MIN = 24'sh800000;
  localparam longint OUT_MAX = 8388607;
  localparam longint OUT_MIN = -8388608;

  // Waveform code the block treats as "no carrier", and the first unused register index.
  localparam logic [1:0]           WAVE_NONE    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG   = 3'd4;

  typedef struct {
    bit                    is_reg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic signed [23:0]    smp;
    logic                  blk;
    bit                    typed;
    logic signed [23:0]    want;
  } dir_row_t;

  typedef struct {
    rmh_in_t            beat;
    bit                 typed;
    logic signed [23:0] want;
  } stim_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  rmh_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  rmh_out_t              out_data;

  ring_modulator_with_highpass dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: registers, phase accumulator and filter history.
  logic [1:0]         wave_r;
  logic [23:0]        step_r;
  logic [15:0]        coeff_r;
  logic [16:0]        gain_r;
  logic [23:0]        phase_acc;
  logic signed [23:0] lp_hist;
  longint             quarter_wave [QTAB_LEN];

  rmh_out_t  want_q [$];
  stim_t     batch_q [$];
  dir_row_t  dir_tab [DIR_ROWS];
  int        mismatches = 0;
  int        beats_in   = 0;
  bit        calm       = 1'b0;
  bit        gaps_on    = 1'b1;

  // sin(a) for a in [0, pi/2] in Q30, Q1.16 result, by a truncated Taylor series.
  function automatic longint taylor_sine_q16(input longint unsigned ang);
    longint unsigned a2;
    longint unsigned term;
    longint unsigned acc;
    int              k;
    a2   = (ang * ang) >> 30;
    term = ang;
    acc  = ang;
    for (k = 1; k <= 8; k++) begin
      term = ((term * a2) >> 30) / longint'(unsigned'((2 * k) * (2 * k + 1)));
      if (k % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    return longint'((acc + 64'd8192) >> 14);
  endfunction

  // Expected output beat for one accepted sample; advances filter and phase.
  function automatic rmh_out_t ring_mod_predict(input rmh_in_t beat);
    longint      x;
    longint      d;
    longint      lp;
    longint      hp;
    longint      car;
    longint      v;
    longint      r;
    logic [23:0] stp;
    logic [1:0]  quad;
    int unsigned qidx;
    rmh_out_t    res;
    x       = longint'($signed(beat.sample_in));
    d       = longint'(lp_hist) - x;
    lp      = x + ((d * longint'(coeff_r) + 32768) >>> 16);
    lp_hist = lp[23:0];
    hp      = x - lp;

    stp       = (step_r == 24'd0) ? 24'd1 : step_r;
    phase_acc = phase_acc + stp;

    case (wave_r)
      WAVE_SINE: begin
        quad = phase_acc[PHASE_BITS-1 -: 2];
        qidx = phase_acc[PHASE_BITS-3 -: SINE_TABLE_BITS];
        if (quad[0]) begin
          qidx = (1 << SINE_TABLE_BITS) - qidx;
        end
        car = quarter_wave[qidx];
        if (quad[1]) begin
          car = -car;
        end
        car = (longint'(UNITY_Q16) - car) / 2;
      end
      WAVE_SAW:    car = longint'(phase_acc >> (PHASE_BITS - 16));
      WAVE_SQUARE: car = phase_acc[PHASE_BITS-1] ? longint'(UNITY_Q16) : 0;
      default:     car = 0;
    endcase

    v = hp * car * longint'(gain_r);
    r = (v + (longint'(1) <<< 31)) >>> 32;
    if (r > OUT_MAX) begin
      r = OUT_MAX;
    end
    if (r < OUT_MIN) begin
      r = OUT_MIN;
    end
    res.mod_out       = r[23:0];
    res.block_end_res = beat.block_end;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 30) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // Register write, only once every expected beat has come out and the pipe has drained.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    while (want_q.size() != 0) @(posedge clk);
    repeat (CFG_PAUSE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_WAVEFORM:   wave_r  = val[1:0];
      CFG_PHASE_STEP: step_r  = val[23:0];
      CFG_HP_COEFF:   coeff_r = val[15:0];
      CFG_OUT_GAIN:   gain_r  = val[16:0];
      default: ;
    endcase
  endtask

  // Offer every queued sample; valid stays up across back-to-back beats.
  task automatic drive_batch();
    int unsigned gap;
    rmh_out_t    pred;
    stim_t       s;
    while (batch_q.size() != 0) begin
      s = batch_q.pop_front();
      in_valid <= 1'b1;
      in_data  <= s.beat;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      pred = ring_mod_predict(s.beat);
      if (s.typed) begin
        pred.mod_out = s.want;
      end
      want_q.push_back(pred);
      beats_in++;
      gap = 0;
      if (!calm && gaps_on && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 18);
      end
      if (gap != 0 || batch_q.size() == 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic logic signed [23:0] random_sample();
    case ($urandom_range(0, 9))
      0:       return S_MAX;
      1:       return S_MIN;
      2, 3:    return 24'(int'($urandom_range(0, 2047)) - 1024);
      default: return 24'($urandom);
    endcase
  endfunction

  // New settings for a random phase; extremes come up often, unused data bits are noise.
  task automatic randomize_regs();
    logic [CFG_DATA_W-1:0] v;
    v = 24'($urandom);
    v[1:0] = ($urandom_range(0, 9) == 0) ? WAVE_NONE : 2'($urandom_range(0, 2));
    write_reg(CFG_WAVEFORM, v);

    case ($urandom_range(0, 5))
      0:       v = 24'h000000;
      1:       v = 24'h000001;
      2:       v = 24'hFFFFFF;
      3:       v = 24'h800000;
      default: v = 24'($urandom);
    endcase
    write_reg(CFG_PHASE_STEP, v);

    v = 24'($urandom);
    case ($urandom_range(0, 4))
      0:       v[15:0] = 16'h0000;
      1:       v[15:0] = 16'hFFFF;
      default: ;
    endcase
    write_reg(CFG_HP_COEFF, v);

    v = 24'($urandom);
    case ($urandom_range(0, 6))
      0:       v[16:0] = 17'd0;
      1:       v[16:0] = 17'd1;
      2:       v[16:0] = UNITY_Q16;
      3:       v[16:0] = 17'h1FFFF;
      default: v[16:0] = 17'($urandom_range(0, 131071));
    endcase
    write_reg(CFG_OUT_GAIN, v);

    if ($urandom_range(0, 3) == 0) begin
      write_reg(CFG_NO_REG + 3'($urandom_range(0, 3)), 24'($urandom));
    end
  endtask

  // Output side: compare each accepted beat with the oldest expected one.
  rmh_out_t head_want;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (want_q.size() == 0) begin
        report_mismatch($sformatf("output beat %0d with nothing expected",
                                  $signed(out_data.mod_out)));
      end else begin
        head_want = want_q.pop_front();
        if (out_data.mod_out !== head_want.mod_out) begin
          report_mismatch($sformatf("mod_out got %0d want %0d",
                                    $signed(out_data.mod_out), $signed(head_want.mod_out)));
        end
        if (out_data.block_end_res !== head_want.block_end_res) begin
          report_mismatch($sformatf("block_end_res got %b want %b",
                                    out_data.block_end_res, head_want.block_end_res));
        end
      end
    end
  end

  // Receiver stalls: random bursts, one long hold-off to fill the block, none when calm.
  int unsigned stall_left = 0;
  int unsigned hold_left  = 0;
  bit          stall_on   = 1'b0;
  bit          hold_done  = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && beats_in >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_on   = ($urandom_range(0, 2) == 0);
        stall_left = stall_on ? $urandom_range(1, 18) : $urandom_range(1, 40);
      end
      stall_left--;
      out_stall <= stall_on;
    end
  end

  // Watchdog for a hung handshake.
  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int    i;
    int    ph;
    int    n;
    stim_t s;

    for (i = 0; i < QTAB_LEN; i++) begin
      quarter_wave[i] = taylor_sine_q16((HALF_PI_Q30 * 64'(i)) >> SINE_TABLE_BITS);
    end
    wave_r    = WAVE_SINE;
    step_r    = 24'd1;
    coeff_r   = '0;
    gain_r    = '0;
    phase_acc = '0;
    lp_hist   = '0;

    // Directed rows: zero expectations are typed where gain, coefficient or carrier is zero.
    dir_tab = '{
      '{1'b0, '0, '0, S_MAX, 1'b0, 1'b1, 24'sd0},
      '{1'b0, '0, '0, S_MIN, 1'b1, 1'b1, 24'sd0},
      '{1'b0, '0, '0, 24'sd0, 1'b0, 1'b1, 24'sd0},
      '{1'b1, CFG_OUT_GAIN, 24'hFFFFFF, '0, 1'b0, 1'b0, '0},
      '{1'b0, '0, '0, S_MAX, 1'b0, 1'b1, 24'sd0},
      '{1'b0, '0, '0, S_MIN, 1'b1, 1'b1, 24'sd0},
      '{1'b1, CFG_HP_COEFF, 24'h00FFFF, '0, 1'b0, 1'b0, '0},
      '{1'b1, CFG_WAVEFORM, 24'(WAVE_SQUARE), '0, 1'b0, 1'b0, '0},
      '{1'b1, CFG_PHASE_STEP, 24'h800000, '0, 1'b0, 1'b0, '0},
      '{1'b0, '0, '0, S_MAX, 1'b1, 1'b0, '0},
      '{1'b0, '0, '0, S_MIN, 1'b0, 1'b0, '0},
      '{1'b0, '0, '0, S_MAX, 1'b0, 1'b0, '0},
      '{1'b0, '0, '0, S_MIN, 1'b1, 1'b0, '0},
      '{1'b1, CFG_WAVEFORM, 24'(WAVE_NONE), '0, 1'b0, 1'b0, '0},
      '{1'b0, '0, '0, S_MAX, 1'b0, 1'b1, 24'sd0},
      '{1'b0, '0, '0, S_MIN, 1'b0, 1'b1, 24'sd0},
      '{1'b1, CFG_WAVEFORM, 24'(WAVE_SAW), '0, 1'b0, 1'b0, '0},
      '{1'b1, CFG_PHASE_STEP, 24'h000000, '0, 1'b0, 1'b0, '0},
      '{1'b0, '0, '0, S_MAX, 1'b0, 1'b0, '0},
      '{1'b0, '0, '0, S_MIN, 1'b0, 1'b0, '0},
      '{1'b0, '0, '0, 24'sd0, 1'b1, 1'b0, '0},
      '{1'b1, CFG_WAVEFORM, 24'(WAVE_SINE), '0, 1'b0, 1'b0, '0},
      '{1'b1, CFG_PHASE_STEP, 24'hFFFFFF, '0, 1'b0, 1'b0, '0},
      '{1'b1, CFG_OUT_GAIN, 24'h000001, '0, 1'b0, 1'b0, '0},
      '{1'b0, '0, '0, S_MAX, 1'b0, 1'b0, '0},
      '{1'b0, '0, '0, S_MIN, 1'b0, 1'b0, '0},
      '{1'b1, CFG_OUT_GAIN, 24'(UNITY_Q16), '0, 1'b0, 1'b0, '0},
      '{1'b1, CFG_HP_COEFF, 24'h008000, '0, 1'b0, 1'b0, '0},
      '{1'b1, CFG_PHASE_STEP, 24'h040000, '0, 1'b0, 1'b0, '0},
      '{1'b0, '0, '0, S_MAX, 1'b0, 1'b0, '0},
      '{1'b0, '0, '0, 24'shFFFFFF, 1'b1, 1'b0, '0},
      '{1'b0, '0, '0, 24'sd1, 1'b0, 1'b0, '0},
      '{1'b0, '0, '0, S_MIN, 1'b0, 1'b0, '0},
      '{1'b1, CFG_NO_REG + 3'd1, 24'hFFFFFF, '0, 1'b0, 1'b0, '0},
      '{1'b0, '0, '0, S_MAX, 1'b0, 1'b0, '0},
      '{1'b0, '0, '0, S_MIN, 1'b1, 1'b0, '0},
      '{1'b1, CFG_OUT_GAIN, 24'h000000, '0, 1'b0, 1'b0, '0},
      '{1'b0, '0, '0, S_MAX, 1'b0, 1'b1, 24'sd0}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table; a register row first flushes the samples gathered so far.
    for (i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].is_reg) begin
        drive_batch();
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        s.beat.sample_in = dir_tab[i].smp;
        s.beat.block_end = dir_tab[i].blk;
        s.typed          = dir_tab[i].typed;
        s.want           = dir_tab[i].want;
        batch_q.push_back(s);
      end
    end
    drive_batch();

    // Random phases, each under fresh settings; the last one runs without idling.
    for (ph = 0; ph < N_PHASES; ph++) begin
      randomize_regs();
      calm    = (ph == N_PHASES - 1);
      gaps_on = (ph % 3 != 2);
      for (n = 0; n < PHASE_LEN; n++) begin
        s.beat.sample_in = random_sample();
        s.beat.block_end = ($urandom_range(0, 7) == 0);
        s.typed          = 1'b0;
        s.want           = '0;
        batch_q.push_back(s);
      end
      drive_batch();
    end

    while (want_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
